[hw/rtl/nspb_pkg.sv]
// Package for the nearest-neighbor scaling blit core.
// Holds the field widths, command, status and register codes, the result
// record and the sequencer state type. No dependencies.
package nspb_pkg;

  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 14;
  localparam int PITCH_W     = 16;
  localparam int DEPTH_W     = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PIXEL_W     = 32;
  localparam int RIDX_W      = 26;
  localparam int WOFF_W      = 28;
  localparam int BPP_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = DIM_W + FRAC_W;
  localparam int ACC_W       = 41;
  localparam int PROD_W      = DIM_W + PITCH_W;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DEPTH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_PITCH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_DEPTH    = 3'd6;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;

  localparam logic [BPP_W-1:0] BPP_2 = 3'd2;
  localparam logic [BPP_W-1:0] BPP_3 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_4 = 3'd4;

  typedef struct packed {
    logic                read_valid;
    logic [RIDX_W-1:0]   read_index;
    logic                write_valid;
    logic [WOFF_W-1:0]   write_offset;
    logic [PIXEL_W-1:0]  write_data;
    logic [BPP_W-1:0]    write_bytes;
    logic                frame_done;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_ADV  = 8'b0001_0000,
    S_RIDX = 8'b0010_0000,
    S_RSUM = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

[hw/rtl/nearest_scale_pixel_blit_core.sv]
// Top level of the nearest-neighbor scaling blit core.
// Sequencer, shared restoring divider, shared multiplier and result register.
// Depends on nspb_pkg.
//
// Usage: the in_ channel carries commands. in_tuser is the command (start
// frame or pixel) and in_tdata the RGBA source word of a pixel beat. Every
// accepted beat yields exactly one out_ beat, which asks for the next source
// word (read fields), reports a converted destination pixel (write fields),
// or ends the frame (out_tlast, with a status code on errors).
// Registers are written on the cfg_ port at any edge with cfg_we high.
// The result of a start beat is formed as follows: the single radix-2
// divider computes the 29-bit horizontal scale step and then the vertical
// one, and the source address is formed in S_RIDX and S_RSUM. For a pixel
// beat the one multiplier is used in turn for the row offset, the column
// offset and the source address; the pixel that ends the frame skips the
// source address. An error start or a pixel beat with no frame active goes
// straight to the result beat.
// One beat is in flight at a time; in_tready rises in the cycle after the
// result beat has been taken, and a stalled receiver holds the whole block.
// Reset clears the sequencer and the frame-active flag and returns every
// configuration register to its reset value.
module nearest_scale_pixel_blit_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nspb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nspb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: source_pixel.
  input  logic [nspb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Fields from bit 0: command.
  input  logic [nspb_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: read_index, write_offset, write_data, write_bytes.
  output logic [nspb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Fields from bit 0: read_valid, write_valid, status.
  output logic [nspb_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast
);

  import nspb_pkg::*;

  localparam logic [DIM_W+1:0] MaxDimL   = (DIM_W+2)'(MAX_DIM);
  localparam int               DivSteps  = STEP_W;
  localparam int               DivCntW   = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return ({2'b00, v} > MaxDimL) ? MaxDimL[DIM_W-1:0] : v;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_coord(input logic [ACC_W-1:0] acc,
                                                   input logic [DIM_W-1:0] limit);
    logic [ACC_W-FRAC_W-1:0] c;
    logic [DIM_W-1:0]        res;
    c = acc[ACC_W-1:FRAC_W];
    if (limit == '0) begin
      res = '0;
    end else if (c >= (ACC_W-FRAC_W)'(limit)) begin
      res = limit - 1'b1;
    end else begin
      res = c[DIM_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [PIXEL_W-1:0] convert_pixel(input logic [PIXEL_W-1:0] rgba,
                                                       input logic [BPP_W-1:0] nb);
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic [PIXEL_W-1:0] res;
    r = rgba[7:0];
    g = rgba[15:8];
    b = rgba[23:16];
    a = rgba[31:24];
    case (nb)
      BPP_4:   res = {a, r, g, b};
      BPP_3:   res = {8'h00, r, g, b};
      default: res = {16'h0000, b[7:3], g[7:2], r[7:3]};
    endcase
    return res;
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0]    src_width_r;
  logic [DIM_W-1:0]    src_height_r;
  logic [STRIDE_W-1:0] src_stride_r;
  logic [DIM_W-1:0]    scr_width_r;
  logic [DIM_W-1:0]    scr_height_r;
  logic [PITCH_W-1:0]  scr_pitch_r;
  logic [DEPTH_W-1:0]  scr_depth_r;

  // Frame state.
  state_t              state_r,  state_nxt;
  logic                active_r, active_nxt;
  logic [DIM_W-1:0]    col_r,    col_nxt;
  logic [DIM_W-1:0]    row_r,    row_nxt;
  logic [STEP_W-1:0]   step_x_r, step_x_nxt;
  logic [STEP_W-1:0]   step_y_r, step_y_nxt;
  logic [ACC_W-1:0]    acc_x_r,  acc_x_nxt;
  logic [ACC_W-1:0]    acc_y_r,  acc_y_nxt;
  logic [BPP_W-1:0]    bpp_r,    bpp_nxt;
  logic [PIXEL_W-1:0]  pix_r,    pix_nxt;

  // Divider.
  logic [STEP_W-1:0]   div_num_r, div_num_nxt;
  logic [DIM_W-1:0]    div_rem_r, div_rem_nxt;
  logic [DIM_W-1:0]    div_d_r,   div_d_nxt;
  logic [DivCntW-1:0]  div_cnt_r, div_cnt_nxt;
  logic                div_y_r,   div_y_nxt;

  // Multiplier and address datapath.
  logic [DIM_W-1:0]    mul_a;
  logic [PITCH_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_r,     mul_nxt;
  logic [WOFF_W-1:0]   sum_r,     sum_nxt;
  logic [DIM_W-1:0]    sx_r,      sx_nxt;

  result_t             res_r,     res_nxt;

  logic [DIM_W-1:0]    sw_sat, sh_sat, dw_sat, dh_sat;
  logic [DEPTH_W:0]    depth_sum;
  logic [3:0]          nb;
  logic                size_zero, depth_bad;
  logic [DIM_W:0]      div_trial;
  logic                div_ge;
  logic [STEP_W-1:0]   div_quot;
  logic [DIM_W-1:0]    col_inc, row_inc;
  logic                in_acc;

  assign sw_sat    = sat_dim(src_width_r);
  assign sh_sat    = sat_dim(src_height_r);
  assign dw_sat    = sat_dim(scr_width_r);
  assign dh_sat    = sat_dim(scr_height_r);
  assign depth_sum = {1'b0, scr_depth_r} + (DEPTH_W+1)'(7);
  assign nb        = depth_sum[DEPTH_W:3];
  assign size_zero = (sw_sat == '0) || (sh_sat == '0) || (dw_sat == '0) || (dh_sat == '0);
  assign depth_bad = (nb != 4'(BPP_2)) && (nb != 4'(BPP_3)) && (nb != 4'(BPP_4));

  assign div_trial = {div_rem_r, div_num_r[STEP_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_d_r};
  assign div_quot  = {div_num_r[STEP_W-2:0], div_ge};

  assign col_inc   = col_r + 1'b1;
  assign row_inc   = row_r + 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {(OUT_TDATA_W-RIDX_W-WOFF_W-PIXEL_W-BPP_W)'(0), res_r.write_bytes,
                       res_r.write_data, res_r.write_offset, res_r.read_index};
  assign out_tuser  = {res_r.status, res_r.write_valid, res_r.read_valid};
  assign out_tlast  = res_r.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= '0;
      src_height_r <= '0;
      src_stride_r <= '0;
      scr_width_r  <= '0;
      scr_height_r <= '0;
      scr_pitch_r  <= '0;
      scr_depth_r  <= DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
        REG_SRC_STRIDE: src_stride_r <= cfg_data[STRIDE_W-1:0];
        REG_SCR_WIDTH:  scr_width_r  <= cfg_data[DIM_W-1:0];
        REG_SCR_HEIGHT: scr_height_r <= cfg_data[DIM_W-1:0];
        REG_SCR_PITCH:  scr_pitch_r  <= cfg_data[PITCH_W-1:0];
        REG_SCR_DEPTH:  scr_depth_r  <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    step_x_nxt  = step_x_r;
    step_y_nxt  = step_y_r;
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    bpp_nxt     = bpp_r;
    pix_nxt     = pix_r;
    div_num_nxt = div_num_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    div_cnt_nxt = div_cnt_r;
    div_y_nxt   = div_y_r;
    sum_nxt     = sum_r;
    sx_nxt      = sx_r;
    res_nxt     = res_r;
    mul_a       = row_r;
    mul_b       = scr_pitch_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          pix_nxt = in_tdata[PIXEL_W-1:0];
          if (in_tuser[0] == CMD_START) begin
            active_nxt = 1'b0;
            state_nxt  = S_OUT;
            if (size_zero) begin
              res_nxt.frame_done = 1'b1;
              res_nxt.status     = STATUS_ZERO_SIZE;
            end else if (depth_bad) begin
              res_nxt.frame_done = 1'b1;
              res_nxt.status     = STATUS_BAD_DEPTH;
            end else begin
              bpp_nxt     = nb[BPP_W-1:0];
              acc_x_nxt   = '0;
              acc_y_nxt   = '0;
              col_nxt     = '0;
              row_nxt     = '0;
              active_nxt  = 1'b1;
              div_num_nxt = {sw_sat, FRAC_W'(0)};
              div_d_nxt   = dw_sat;
              div_rem_nxt = '0;
              div_cnt_nxt = '0;
              div_y_nxt   = 1'b0;
              state_nxt   = S_DIV;
            end
          end else if (active_r) begin
            state_nxt = S_MUL1;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        div_rem_nxt = div_ge ? DIM_W'(div_trial - {1'b0, div_d_r}) : div_trial[DIM_W-1:0];
        div_num_nxt = div_quot;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DivLast) begin
          if (!div_y_r) begin
            step_x_nxt  = div_quot;
            div_num_nxt = {sh_sat, FRAC_W'(0)};
            div_d_nxt   = dh_sat;
            div_rem_nxt = '0;
            div_cnt_nxt = '0;
            div_y_nxt   = 1'b1;
          end else begin
            step_y_nxt = div_quot;
            state_nxt  = S_RIDX;
          end
        end
      end
      S_MUL1: begin
        mul_a     = row_r;
        mul_b     = scr_pitch_r;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        sum_nxt   = mul_r[WOFF_W-1:0];
        mul_a     = col_r;
        mul_b     = PITCH_W'(bpp_r);
        state_nxt = S_ADV;
      end
      S_ADV: begin
        res_nxt.write_valid  = 1'b1;
        res_nxt.write_offset = sum_r + mul_r[WOFF_W-1:0];
        res_nxt.write_data   = convert_pixel(pix_r, bpp_r);
        res_nxt.write_bytes  = bpp_r;
        state_nxt            = S_RIDX;
        if (col_inc >= dw_sat) begin
          col_nxt   = '0;
          acc_x_nxt = '0;
          acc_y_nxt = acc_y_r + ACC_W'(step_y_r);
          row_nxt   = row_inc;
          if (row_inc >= dh_sat) begin
            active_nxt         = 1'b0;
            row_nxt            = '0;
            acc_y_nxt          = '0;
            res_nxt.frame_done = 1'b1;
            state_nxt          = S_OUT;
          end
        end else begin
          col_nxt   = col_inc;
          acc_x_nxt = acc_x_r + ACC_W'(step_x_r);
        end
      end
      S_RIDX: begin
        mul_a     = clamp_coord(acc_y_r, sh_sat);
        mul_b     = PITCH_W'(src_stride_r);
        sx_nxt    = clamp_coord(acc_x_r, sw_sat);
        state_nxt = S_RSUM;
      end
      S_RSUM: begin
        res_nxt.read_valid = 1'b1;
        res_nxt.read_index = RIDX_W'(mul_r + PROD_W'(sx_r));
        state_nxt          = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign mul_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    step_x_r  <= step_x_nxt;
    step_y_r  <= step_y_nxt;
    acc_x_r   <= acc_x_nxt;
    acc_y_r   <= acc_y_nxt;
    bpp_r     <= bpp_nxt;
    pix_r     <= pix_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_y_r   <= div_y_nxt;
    mul_r     <= mul_nxt;
    sum_r     <= sum_nxt;
    sx_r      <= sx_nxt;
    res_r     <= res_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result beat is pending");

  a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.status != STATUS_OK) |->
      (res_r.frame_done && !res_r.read_valid && !res_r.write_valid && !active_r))
    else $error("error result does not end the frame cleanly");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.frame_done) |-> (!active_r && !res_r.read_valid))
    else $error("frame end beat while a frame is still active");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RSUM) |=> (state_r == S_OUT && res_r.read_valid))
    else $error("source address step did not produce a read request");

endmodule
